>>> src/clbs_pkg.sv
// Shared types and constants for the colored lightmap block shader.
// Used by every module under src; has no dependencies of its own.
package clbs_pkg;

    // Block geometry: side is (1 << BASE_BLOCK_LOG2) >> mip_level texels.
    localparam int BASE_BLOCK_LOG2 = 4;
    localparam int CNT_W           = BASE_BLOCK_LOG2;
    localparam int SHIFT_W         = $clog2(BASE_BLOCK_LOG2 + 1);
    localparam int MIP_W           = 2;

    // Channel and fixed-point formats.
    localparam int NCH        = 3;
    localparam int LIGHT_W    = 8;
    localparam int EDGE_W     = 27;
    localparam int EDGE_SHIFT = 17;
    localparam int SPAN_W     = 22;
    localparam int SPAN_SHIFT = 6;
    localparam int PROD_W     = SPAN_W + LIGHT_W + 1;
    localparam int CH0_SHIFT  = 11 + 10;
    localparam int CH12_SHIFT = 8 + 10;
    localparam int CH0_MAX    = 31;
    localparam int CH12_MAX   = 255;
    localparam int COLOR_W    = 16;

    // Input item kinds.
    localparam logic REQ_CORNER = 1'b0;
    localparam logic REQ_TEXEL  = 1'b1;

    // Corner indexes.
    localparam int CORNER_W = 2;
    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd3;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MIP_LEVEL = '0;

    typedef logic [MIP_W-1:0]                  mip_t;
    typedef logic [CORNER_W-1:0]               corner_t;
    typedef logic [NCH-1:0][LIGHT_W-1:0]       rgb8_t;
    typedef logic [COLOR_W-1:0]                color_t;

    // Interpolated lights for the texel being shaded, plus its walk position flags.
    typedef struct packed {
        logic [NCH-1:0][SPAN_W-1:0] light;
        logic                       last_in_row;
        logic                       last_in_block;
    } lit_state_t;

endpackage

>>> src/clbs_cfg.sv
// APB register file for the lightmap block shader: holds mip_level.
// Depends on clbs_pkg.
module clbs_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [clbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output clbs_pkg::mip_t                      mip_level
);
    import clbs_pkg::*;

    mip_t mip_reg;
    mip_t mip_next;
    logic wr_mip;

    assign pready = 1'b1;
    assign wr_mip = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_MIP_LEVEL);

    always_comb begin
        mip_next = mip_reg;
        if (wr_mip) begin
            mip_next = pwdata[MIP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mip_reg <= '0;
        end else begin
            mip_reg <= mip_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_MIP_LEVEL) begin
            prdata = APB_DATA_W'(mip_reg);
        end
    end

    assign mip_level = mip_reg;

endmodule

>>> src/clbs_interp.sv
// Light interpolation state: corner lights, edge lights and steps, span lights
// and steps, and the row/column walk counters. Depends on clbs_pkg.
module clbs_interp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  clbs_pkg::mip_t       mip_level,
    input  logic                 corner_we,
    input  clbs_pkg::corner_t    corner_idx,
    input  clbs_pkg::rgb8_t      corner_light,
    input  logic                 texel_en,
    output clbs_pkg::lit_state_t lit
);
    import clbs_pkg::*;

    rgb8_t corner_reg [4];

    logic signed [EDGE_W-1:0] edge_l_reg [NCH];
    logic signed [EDGE_W-1:0] edge_r_reg [NCH];
    logic signed [EDGE_W-1:0] edge_l_step_reg [NCH];
    logic signed [EDGE_W-1:0] edge_r_step_reg [NCH];
    logic signed [SPAN_W-1:0] span_reg [NCH];
    logic signed [SPAN_W-1:0] span_step_reg [NCH];
    logic [CNT_W-1:0]         col_reg;
    logic [CNT_W-1:0]         row_reg;

    logic [SHIFT_W-1:0] shift_amt;
    logic [CNT_W-1:0]   mask;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   row;
    logic               blk_start;
    logic               row_start;
    logic               last_row;
    logic               last_blk;
    logic [CNT_W-1:0]   col_next;
    logic [CNT_W-1:0]   row_next;

    logic signed [EDGE_W-1:0] tl_start [NCH];
    logic signed [EDGE_W-1:0] tr_start [NCH];
    logic signed [EDGE_W-1:0] bl_start [NCH];
    logic signed [EDGE_W-1:0] br_start [NCH];
    logic signed [EDGE_W-1:0] side_l [NCH];
    logic signed [EDGE_W-1:0] side_r [NCH];
    logic signed [EDGE_W-1:0] el_step_new [NCH];
    logic signed [EDGE_W-1:0] er_step_new [NCH];
    logic signed [EDGE_W-1:0] el_cur [NCH];
    logic signed [EDGE_W-1:0] er_cur [NCH];
    logic signed [EDGE_W-1:0] el_step_cur [NCH];
    logic signed [EDGE_W-1:0] er_step_cur [NCH];
    logic signed [EDGE_W-1:0] el_next [NCH];
    logic signed [EDGE_W-1:0] er_next [NCH];
    logic signed [EDGE_W-1:0] el_scaled [NCH];
    logic signed [EDGE_W:0]   edge_gap [NCH];
    logic signed [EDGE_W:0]   gap_scaled [NCH];
    logic signed [SPAN_W-1:0] span_cur [NCH];
    logic signed [SPAN_W-1:0] step_cur [NCH];
    logic signed [SPAN_W-1:0] span_next [NCH];

    // Walk position; counters are masked so a mip change mid-block wraps cleanly.
    always_comb begin
        if (SHIFT_W'(mip_level) > SHIFT_W'(BASE_BLOCK_LOG2)) begin
            shift_amt = '0;
        end else begin
            shift_amt = SHIFT_W'(BASE_BLOCK_LOG2) - SHIFT_W'(mip_level);
        end
        mask      = ~({CNT_W{1'b1}} << shift_amt);
        col       = col_reg & mask;
        row       = row_reg & mask;
        row_start = (col == '0);
        blk_start = row_start && (row == '0);
        last_row  = (col == mask);
        last_blk  = last_row && (row == mask);
        if (last_row) begin
            col_next = '0;
            row_next = last_blk ? '0 : row + 1'b1;
        end else begin
            col_next = col + 1'b1;
            row_next = row;
        end
    end

    // Per-channel interpolation; the three channels are independent.
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            tl_start[k] = $signed({{(EDGE_W-LIGHT_W-EDGE_SHIFT){1'b0}},
                                   corner_reg[CORNER_TL][k], {EDGE_SHIFT{1'b0}}});
            tr_start[k] = $signed({{(EDGE_W-LIGHT_W-EDGE_SHIFT){1'b0}},
                                   corner_reg[CORNER_TR][k], {EDGE_SHIFT{1'b0}}});
            bl_start[k] = $signed({{(EDGE_W-LIGHT_W-EDGE_SHIFT){1'b0}},
                                   corner_reg[CORNER_BL][k], {EDGE_SHIFT{1'b0}}});
            br_start[k] = $signed({{(EDGE_W-LIGHT_W-EDGE_SHIFT){1'b0}},
                                   corner_reg[CORNER_BR][k], {EDGE_SHIFT{1'b0}}});
            side_l[k]      = bl_start[k] - tl_start[k];
            side_r[k]      = br_start[k] - tr_start[k];
            el_step_new[k] = side_l[k] >>> shift_amt;
            er_step_new[k] = side_r[k] >>> shift_amt;

            el_cur[k]      = blk_start ? tl_start[k] : edge_l_reg[k];
            er_cur[k]      = blk_start ? tr_start[k] : edge_r_reg[k];
            el_step_cur[k] = blk_start ? el_step_new[k] : edge_l_step_reg[k];
            er_step_cur[k] = blk_start ? er_step_new[k] : edge_r_step_reg[k];
            el_next[k]     = el_cur[k] + el_step_cur[k];
            er_next[k]     = er_cur[k] + er_step_cur[k];

            el_scaled[k]  = el_cur[k] >>> SPAN_SHIFT;
            edge_gap[k]   = {er_cur[k][EDGE_W-1], er_cur[k]} - {el_cur[k][EDGE_W-1], el_cur[k]};
            gap_scaled[k] = (edge_gap[k] >>> shift_amt) >>> SPAN_SHIFT;

            span_cur[k]  = row_start ? el_scaled[k][SPAN_W-1:0] : span_reg[k];
            step_cur[k]  = row_start ? gap_scaled[k][SPAN_W-1:0] : span_step_reg[k];
            span_next[k] = span_cur[k] + step_cur[k];

            lit.light[k] = span_cur[k];
        end
        lit.last_in_row   = last_row;
        lit.last_in_block = last_blk;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                corner_reg[i] <= '0;
            end
            for (int k = 0; k < NCH; k++) begin
                edge_l_reg[k]      <= '0;
                edge_r_reg[k]      <= '0;
                edge_l_step_reg[k] <= '0;
                edge_r_step_reg[k] <= '0;
                span_reg[k]        <= '0;
                span_step_reg[k]   <= '0;
            end
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            if (corner_we) begin
                corner_reg[corner_idx] <= corner_light;
            end
            if (texel_en) begin
                for (int k = 0; k < NCH; k++) begin
                    edge_l_step_reg[k] <= el_step_cur[k];
                    edge_r_step_reg[k] <= er_step_cur[k];
                    edge_l_reg[k]      <= last_row ? el_next[k] : el_cur[k];
                    edge_r_reg[k]      <= last_row ? er_next[k] : er_cur[k];
                    span_reg[k]        <= span_next[k];
                    span_step_reg[k]   <= step_cur[k];
                end
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> src/clbs_modulate.sv
// Texel modulation: multiplies each color byte by its interpolated light,
// clamps, and packs the result to RGB565. Depends on clbs_pkg.
module clbs_modulate (
    input  logic [clbs_pkg::NCH-1:0][clbs_pkg::SPAN_W-1:0] light,
    input  clbs_pkg::rgb8_t                                 texel,
    output clbs_pkg::color_t                                color_565
);
    import clbs_pkg::*;

    logic signed [PROD_W-1:0] prod [NCH];
    logic [PROD_W-1:0]        scaled [NCH];
    logic [LIGHT_W-1:0]       chan [NCH];

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            prod[k]   = $signed(light[k]) * $signed({1'b0, texel[k]});
            scaled[k] = (k == 0) ? (PROD_W'(prod[k]) >> CH0_SHIFT)
                                 : (PROD_W'(prod[k]) >> CH12_SHIFT);
            // A negative light product clamps to black.
            if (prod[k][PROD_W-1]) begin
                chan[k] = '0;
            end else if (k == 0 && scaled[k] > PROD_W'(CH0_MAX)) begin
                chan[k] = LIGHT_W'(CH0_MAX);
            end else if (k != 0 && scaled[k] > PROD_W'(CH12_MAX)) begin
                chan[k] = LIGHT_W'(CH12_MAX);
            end else begin
                chan[k] = scaled[k][LIGHT_W-1:0];
            end
        end
        color_565 = {chan[2][7:3], chan[1][7:2], chan[0][4:0]};
    end

endmodule

>>> src/colored_lightmap_block_shader_unit.sv
// Top level of the colored lightmap block shader: input register, light
// interpolation, modulation and result register. Depends on clbs_pkg,
// clbs_cfg, clbs_interp and clbs_modulate.
//
//   Channel   Direction   Transfers
//   s_*       in          corner light samples and texel colors (tuser says which)
//   m_*       out         one RGB565 lit texel for each texel item, none for corners
//   APB       in/out      mip_level register at byte address 0
//
// An accepted item sits in the input register, where its texel result is
// computed and captured in the result register; one item per cycle is
// sustained while m_tready is high. The per-block and per-row setup of the edge
// and span lights happens in the same cycle as the texel that starts the block
// or row. Reset is synchronous and active low and clears all interpolation
// state and counters. A stall on m_tready holds the result register and stops
// texel items in the input register; corner items still drain past it.
module colored_lightmap_block_shader_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0: light_c0, light_c1, light_c2, texel_c0, texel_c1, texel_c2.
    input  logic [47:0]                      s_tdata,
    // tuser from bit 0: req_type, corner[1:0].
    input  logic [2:0]                       s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: color_565.
    output logic [15:0]                      m_tdata,
    // tlast: last_in_row.
    output logic                             m_tlast,
    // tuser: last_in_block.
    output logic                             m_tuser,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clbs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [clbs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [clbs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import clbs_pkg::*;

    mip_t mip_level;

    // Input register.
    logic    in_vld_reg;
    logic    in_vld_next;
    logic    in_type_reg;
    corner_t in_corner_reg;
    rgb8_t   in_light_reg;
    rgb8_t   in_texel_reg;
    logic    in_take;

    // Result register.
    logic   out_vld_reg;
    logic   out_vld_next;
    color_t out_color_reg;
    logic   out_lrow_reg;
    logic   out_lblk_reg;

    logic       advance;
    logic       texel_en;
    logic       corner_we;
    lit_state_t lit;
    color_t     color_565;

    clbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .mip_level (mip_level)
    );

    // A corner item never needs the result register, so it retires at once;
    // a texel item retires when the result register is free or being drained.
    assign advance   = in_vld_reg && ((in_type_reg == REQ_CORNER) || !out_vld_reg || m_tready);
    assign texel_en  = advance && (in_type_reg == REQ_TEXEL);
    assign corner_we = advance && (in_type_reg == REQ_CORNER);
    assign s_tready  = !in_vld_reg || advance;
    assign in_take   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (texel_en) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_type_reg   <= s_tuser[0];
            in_corner_reg <= s_tuser[2:1];
            in_light_reg  <= s_tdata[23:0];
            in_texel_reg  <= s_tdata[47:24];
        end
        if (texel_en) begin
            out_color_reg <= color_565;
            out_lrow_reg  <= lit.last_in_row;
            out_lblk_reg  <= lit.last_in_block;
        end
    end

    clbs_interp u_interp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mip_level    (mip_level),
        .corner_we    (corner_we),
        .corner_idx   (in_corner_reg),
        .corner_light (in_light_reg),
        .texel_en     (texel_en),
        .lit          (lit)
    );

    clbs_modulate u_modulate (
        .light     (lit.light),
        .texel     (in_texel_reg),
        .color_565 (color_565)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_color_reg;
    assign m_tlast  = out_lrow_reg;
    assign m_tuser  = out_lblk_reg;

endmodule
